>>> design/crt_pkg.sv
// crt_pkg: shared types and constants of the color region tracker.
// Used by every module of the block; depends on nothing.

package crt_pkg;

	// Register map, word index (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_COLOR_SELECT    = 3'd0,
		REG_RED_THRESHOLD   = 3'd1,
		REG_GREEN_THRESHOLD = 3'd2,
		REG_BLUE_THRESHOLD  = 3'd3,
		REG_IMAGE_WIDTH     = 3'd4,
		REG_GRAY_MODE       = 3'd5
	} crt_reg_t;

	// Target channel codes of color_select
	typedef enum logic [1:0] {
		COLOR_RED   = 2'd0,
		COLOR_GREEN = 2'd1,
		COLOR_BLUE  = 2'd2,
		COLOR_NONE  = 2'd3
	} crt_color_t;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [1:0]  RST_COLOR_SELECT = COLOR_RED;
	localparam logic [7:0]  RST_THRESHOLD    = 8'd128;
	localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd640;

	localparam logic [15:0] OFFSET_NONE = 16'hFFFF;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  color_select;
		logic [7:0]  red_threshold;
		logic [7:0]  green_threshold;
		logic [7:0]  blue_threshold;
		logic [15:0] image_width;
		logic        gray_mode;
	} crt_cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} crt_pixel_t;

	typedef struct packed {
		logic               found;
		logic [15:0]        offset;
		logic [15:0]        last_match_row;
		logic [15:0]        widest_end_col;
		logic [15:0]        matching_rows;
		logic [15:0]        widest_count;
		logic [31:0]        pixel_count;
		logic signed [16:0] horiz_mid;
		logic signed [16:0] vert_mid;
	} crt_result_t;

endpackage

>>> design/color_region_tracker_unit.sv
// color_region_tracker_unit: top level of the color region tracker.
// Depends on crt_pkg, crt_cfg_regs, crt_classify, crt_stats, crt_out_buf.
//
//  channel   | dir | handshake         | content
//  ----------+-----+-------------------+------------------------------------------
//  s_*       | in  | s_tvalid/s_tready | one RGB pixel per beat, tlast = frame end
//  m_*       | out | m_tvalid/m_tready | one statistics beat per frame
//  APB p*    | in  | psel/penable      | six config registers at 4*index
//
// One pixel per clock, sustained apart from the stall below. A pixel is captured
// in the input register and is classified and folded into the statistics as it
// leaves; when a frame-end pixel leaves, the frame's result beat goes into the buffer that drives m_*.
// The pixel side stalls only when a frame-end pixel sits in the input
// register and the two-entry result buffer is full.
// Reset clears all statistics, empties the buffer and loads the register
// defaults (red target, thresholds 128, width 640, gray mode off).

module color_region_tracker_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic                           s_tlast,   // frame_end
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [151:0]                   m_tdata,   // offset[15:0], last_match_row[31:16],
	                                                  // widest_end_col[47:32],
	                                                  // matching_rows[63:48],
	                                                  // widest_count[79:64],
	                                                  // pixel_count[111:80],
	                                                  // horiz_mid[128:112],
	                                                  // vert_mid[145:129], zero[151:146]
	output logic                           m_tuser,   // found
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [crt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [crt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [crt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	crt_pkg::crt_cfg_t    cfg;
	crt_pkg::crt_pixel_t  pix_s1;
	logic                 valid_s1;
	logic                 go_s1;      // input register hands its pixel on this cycle
	logic                 s_beat;
	logic                 match;
	logic                 res_push;
	logic                 buf_space;
	crt_pkg::crt_result_t res;
	crt_pkg::crt_result_t out_res;

	crt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register. Only a frame-end pixel needs buffer room; ordinary
	// pixels never wait. buf_space is registered, so no path from m_tready.
	assign go_s1    = valid_s1 && (!pix_s1.frame_end || buf_space);
	assign s_tready = !valid_s1 || go_s1;
	assign s_beat   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_beat) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			pix_s1.red       <= s_tdata[7:0];
			pix_s1.green     <= s_tdata[15:8];
			pix_s1.blue      <= s_tdata[23:16];
			pix_s1.frame_end <= s_tlast;
		end
	end

	crt_classify u_classify (
		.cfg   (cfg),
		.pix   (pix_s1),
		.match (match)
	);

	crt_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (go_s1),
		.match     (match),
		.frame_end (pix_s1.frame_end),
		.res_valid (res_push),
		.res       (res)
	);

	crt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.space     (buf_space),
		.ready     (m_tready),
		.valid     (m_tvalid),
		.data      (out_res)
	);

	assign m_tuser = out_res.found;
	assign m_tdata = {6'd0, out_res.vert_mid, out_res.horiz_mid, out_res.pixel_count,
	                  out_res.widest_count, out_res.matching_rows, out_res.widest_end_col,
	                  out_res.last_match_row, out_res.offset};

	// a result is only written when the buffer has room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> buf_space)
		else $error("result written into a full buffer");

	// a stalled pixel stays put in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(pix_s1)))
		else $error("input register lost a stalled pixel");

	// an ordinary pixel is never held back
	a_no_row_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !pix_s1.frame_end) |-> go_s1)
		else $error("non frame-end pixel stalled");

	// result beats appear only after a frame end was processed
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(res_push))
		else $error("result beat without a frame end");

endmodule

>>> design/crt_cfg_regs.sv
// crt_cfg_regs: APB-style configuration register file.
// Depends on crt_pkg.

module crt_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [crt_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [crt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [crt_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output crt_pkg::crt_cfg_t                 cfg
);

	crt_pkg::crt_cfg_t cfg_q;
	crt_pkg::crt_reg_t reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = crt_pkg::crt_reg_t'(paddr[crt_pkg::APB_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_select    <= crt_pkg::RST_COLOR_SELECT;
			cfg_q.red_threshold   <= crt_pkg::RST_THRESHOLD;
			cfg_q.green_threshold <= crt_pkg::RST_THRESHOLD;
			cfg_q.blue_threshold  <= crt_pkg::RST_THRESHOLD;
			cfg_q.image_width     <= crt_pkg::RST_IMAGE_WIDTH;
			cfg_q.gray_mode       <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				crt_pkg::REG_COLOR_SELECT:    cfg_q.color_select    <= pwdata[1:0];
				crt_pkg::REG_RED_THRESHOLD:   cfg_q.red_threshold   <= pwdata[7:0];
				crt_pkg::REG_GREEN_THRESHOLD: cfg_q.green_threshold <= pwdata[7:0];
				crt_pkg::REG_BLUE_THRESHOLD:  cfg_q.blue_threshold  <= pwdata[7:0];
				crt_pkg::REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[15:0];
				crt_pkg::REG_GRAY_MODE:       cfg_q.gray_mode       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			crt_pkg::REG_COLOR_SELECT:    prdata = {30'd0, cfg_q.color_select};
			crt_pkg::REG_RED_THRESHOLD:   prdata = {24'd0, cfg_q.red_threshold};
			crt_pkg::REG_GREEN_THRESHOLD: prdata = {24'd0, cfg_q.green_threshold};
			crt_pkg::REG_BLUE_THRESHOLD:  prdata = {24'd0, cfg_q.blue_threshold};
			crt_pkg::REG_IMAGE_WIDTH:     prdata = {16'd0, cfg_q.image_width};
			crt_pkg::REG_GRAY_MODE:       prdata = {31'd0, cfg_q.gray_mode};
			default:                      prdata = '0;
		endcase
	end

endmodule

>>> design/crt_classify.sv
// crt_classify: per-pixel threshold test against the selected channel.
// Depends on crt_pkg.

module crt_classify (
	input  crt_pkg::crt_cfg_t   cfg,
	input  crt_pkg::crt_pixel_t pix,
	output logic                match
);

	logic [7:0] g, b;
	logic       r_hi, r_lo, g_hi, g_lo, b_hi, b_lo;

	// gray mode: red sample stands in for all three channels
	assign g = cfg.gray_mode ? pix.red : pix.green;
	assign b = cfg.gray_mode ? pix.red : pix.blue;

	assign r_hi = pix.red > cfg.red_threshold;
	assign r_lo = pix.red < cfg.red_threshold;
	assign g_hi = g > cfg.green_threshold;
	assign g_lo = g < cfg.green_threshold;
	assign b_hi = b > cfg.blue_threshold;
	assign b_lo = b < cfg.blue_threshold;

	always_comb begin
		unique case (crt_pkg::crt_color_t'(cfg.color_select))
			crt_pkg::COLOR_RED:   match = r_hi && g_lo && b_lo;
			crt_pkg::COLOR_GREEN: match = r_lo && g_hi && b_lo;
			crt_pkg::COLOR_BLUE:  match = r_lo && g_lo && b_hi;
			default:              match = 1'b0;
		endcase
	end

endmodule

>>> design/crt_stats.sv
// crt_stats: row and frame statistics, result computation at frame end.
// Depends on crt_pkg.

module crt_stats (
	input  logic                clk,
	input  logic                arst_n,
	input  crt_pkg::crt_cfg_t   cfg,
	input  logic                fire,
	input  logic                match,
	input  logic                frame_end,
	output logic                res_valid,
	output crt_pkg::crt_result_t res
);

	logic [15:0] col_q, row_idx_q, row_cnt_q, row_col_q;
	logic        row_hit_q;
	logic [31:0] total_q;
	logic [15:0] rows_q, last_row_q, best_cnt_q, best_col_q;

	logic [15:0] row_cnt_n, row_col_n;
	logic        row_hit_n;
	logic [31:0] total_n;
	logic [15:0] rows_n, last_row_n, best_cnt_n, best_col_n;
	logic        row_end;
	logic [15:0] last_col;
	logic [16:0] hmid, vmid;

	assign last_col = cfg.image_width - 16'd1;
	assign row_end  = (col_q == last_col) || frame_end;

	always_comb begin
		row_cnt_n  = match ? row_cnt_q + 16'd1 : row_cnt_q;
		row_col_n  = match ? col_q : row_col_q;
		row_hit_n  = row_hit_q || match;
		total_n    = (match && total_q != crt_pkg::COUNT_MAX) ? total_q + 32'd1 : total_q;
		rows_n     = rows_q;
		last_row_n = last_row_q;
		best_cnt_n = best_cnt_q;
		best_col_n = best_col_q;
		if (row_end && row_hit_n) begin
			rows_n     = rows_q + 16'd1;
			last_row_n = row_idx_q;
			// strict compare keeps the first widest row
			if (row_cnt_n > best_cnt_q) begin
				best_cnt_n = row_cnt_n;
				best_col_n = row_col_n;
			end
		end
	end

	assign hmid = {1'b0, best_col_n} - {2'b00, best_cnt_n[15:1]};
	assign vmid = {1'b0, last_row_n} - {2'b00, rows_n[15:1]};

	assign res_valid          = fire && frame_end;
	assign res.found          = total_n != 32'd0;
	assign res.offset         = res.found ? cfg.image_width - hmid[15:0] : crt_pkg::OFFSET_NONE;
	assign res.last_match_row = last_row_n;
	assign res.widest_end_col = best_col_n;
	assign res.matching_rows  = rows_n;
	assign res.widest_count   = best_cnt_n;
	assign res.pixel_count    = total_n;
	assign res.horiz_mid      = hmid;
	assign res.vert_mid       = vmid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_idx_q  <= '0;
			row_cnt_q  <= '0;
			row_col_q  <= '0;
			row_hit_q  <= 1'b0;
			total_q    <= '0;
			rows_q     <= '0;
			last_row_q <= '0;
			best_cnt_q <= '0;
			best_col_q <= '0;
		end else if (fire) begin
			if (frame_end) begin
				col_q      <= '0;
				row_idx_q  <= '0;
				row_cnt_q  <= '0;
				row_col_q  <= '0;
				row_hit_q  <= 1'b0;
				total_q    <= '0;
				rows_q     <= '0;
				last_row_q <= '0;
				best_cnt_q <= '0;
				best_col_q <= '0;
			end else begin
				total_q    <= total_n;
				rows_q     <= rows_n;
				last_row_q <= last_row_n;
				best_cnt_q <= best_cnt_n;
				best_col_q <= best_col_n;
				if (row_end) begin
					col_q     <= '0;
					row_idx_q <= row_idx_q + 16'd1;
					row_cnt_q <= '0;
					row_col_q <= '0;
					row_hit_q <= 1'b0;
				end else begin
					col_q     <= col_q + 16'd1;
					row_cnt_q <= row_cnt_n;
					row_col_q <= row_col_n;
					row_hit_q <= row_hit_n;
				end
			end
		end
	end

endmodule

>>> design/crt_out_buf.sv
// crt_out_buf: two-entry result buffer driving the master stream side.
// Depends on crt_pkg.

module crt_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crt_pkg::crt_result_t push_data,
	output logic                 space,
	input  logic                 ready,
	output logic                 valid,
	output crt_pkg::crt_result_t data
);

	crt_pkg::crt_result_t mem_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           count_q;
	logic                 pop;

	assign valid = count_q != 2'd0;
	assign space = count_q != 2'd2;
	assign pop   = valid && ready;
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			// push and pop together leave the count as it is
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for color_region_tracker_unit (pixel stream in, frame stats out).
// Depends on crt_pkg for the register map, color codes and pixel/result types; reads no files.

module tb_top;

	localparam int unsigned RANDOM_ITEMS = 520;
	localparam int unsigned STRETCH_HALF = 80;
	localparam int unsigned LIMIT_CYCLES = 1_500_000;
	localparam int unsigned DRAIN_CYCLES = 6;    // extra wait in settle() once the owed results have drained
	localparam int unsigned GAP_PCT      = 26;

	// One line of the directed script: a register write or a pixel beat. A pixel
	// row may carry hand-typed expectations for found, offset and pixel count.
	typedef struct {
		bit                  is_cfg;
		crt_pkg::crt_reg_t   reg_idx;
		logic [31:0]         value;
		crt_pkg::crt_pixel_t px;
		bit                  typed;
		logic                found;
		logic [15:0]         offset;
		logic [31:0]         hits;
	} script_row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [23:0]                    s_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
	logic                           s_tlast  = 1'b0; // frame_end
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [151:0]                   m_tdata;         // offset .. vert_mid, see dut port list
	logic                           m_tuser;         // found
	logic                           psel     = 1'b0;
	logic                           penable  = 1'b0;
	logic                           pwrite   = 1'b0;
	logic [crt_pkg::APB_ADDR_W-1:0] paddr    = '0;
	logic [crt_pkg::APB_DATA_W-1:0] pwdata   = '0;
	logic [crt_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	// random idling on both streams; cleared for the long no-gap stretches
	bit gaps_on = 1'b1;

	// shadow copy of the register file
	crt_pkg::crt_cfg_t shadow = '{color_select: crt_pkg::RST_COLOR_SELECT,
		red_threshold: crt_pkg::RST_THRESHOLD, green_threshold: crt_pkg::RST_THRESHOLD,
		blue_threshold: crt_pkg::RST_THRESHOLD, image_width: crt_pkg::RST_IMAGE_WIDTH,
		gray_mode: 1'b0};

	// tracker state as the block should hold it
	logic [15:0] col_ctr      = '0;
	logic [15:0] row_idx      = '0;
	logic [15:0] row_hits     = '0;
	logic [15:0] row_hit_col  = '0;
	logic        row_hit      = 1'b0;
	logic [31:0] hit_total    = '0;
	logic [15:0] hit_rows     = '0;
	logic [15:0] last_hit_row = '0;
	logic [15:0] widest_hits  = '0;
	logic [15:0] widest_col   = '0;

	crt_pkg::crt_result_t frame_stats_q[$];   // frame results still owed by the block
	crt_pkg::crt_result_t want_res, got_res;

	int unsigned mismatches      = 0;
	int unsigned pixels_in       = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes      = 0;

	color_region_tracker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// selected channel strictly above its limit, the other two strictly below
	function automatic bit pixel_hit(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		bit r_hi, r_lo, g_hi, g_lo, b_hi, b_lo;
		r_hi = r > shadow.red_threshold;
		r_lo = r < shadow.red_threshold;
		g_hi = g > shadow.green_threshold;
		g_lo = g < shadow.green_threshold;
		b_hi = b > shadow.blue_threshold;
		b_lo = b < shadow.blue_threshold;
		case (crt_pkg::crt_color_t'(shadow.color_select))
			crt_pkg::COLOR_RED:   return r_hi && g_lo && b_lo;
			crt_pkg::COLOR_GREEN: return r_lo && g_hi && b_lo;
			crt_pkg::COLOR_BLUE:  return r_lo && g_lo && b_hi;
			default:              return 1'b0;
		endcase
	endfunction

	// Folds one accepted pixel into the tracker state; returns 1 with the frame
	// statistics when the pixel closes the frame.
	function automatic bit track_pixel(crt_pkg::crt_pixel_t px,
		output crt_pkg::crt_result_t res);
		logic [7:0]  g, b;
		logic [15:0] last_col;
		logic [16:0] hmid, vmid;
		bit          any;
		g = shadow.gray_mode ? px.red : px.green;
		b = shadow.gray_mode ? px.red : px.blue;
		res = '0;
		if (pixel_hit(px.red, g, b)) begin
			row_hits    = row_hits + 16'd1;
			row_hit_col = col_ctr;
			row_hit     = 1'b1;
			if (hit_total != crt_pkg::COUNT_MAX)
				hit_total = hit_total + 32'd1;
		end
		// width 0 wraps to a last column of 65535
		last_col = shadow.image_width - 16'd1;
		if (col_ctr == last_col || px.frame_end) begin
			if (row_hit) begin
				hit_rows     = hit_rows + 16'd1;
				last_hit_row = row_idx;
				// strictly greater: the first widest row wins ties
				if (row_hits > widest_hits) begin
					widest_hits = row_hits;
					widest_col  = row_hit_col;
				end
			end
			row_idx     = row_idx + 16'd1;
			col_ctr     = '0;
			row_hits    = '0;
			row_hit_col = '0;
			row_hit     = 1'b0;
		end else begin
			col_ctr = col_ctr + 16'd1;
		end
		if (!px.frame_end)
			return 1'b0;

		any  = hit_total != 0;
		hmid = {1'b0, widest_col} - {2'b00, widest_hits[15:1]};
		vmid = {1'b0, last_hit_row} - {2'b00, hit_rows[15:1]};
		res.found          = any;
		res.offset         = any ? shadow.image_width - hmid[15:0] : crt_pkg::OFFSET_NONE;
		res.last_match_row = last_hit_row;
		res.widest_end_col = widest_col;
		res.matching_rows  = hit_rows;
		res.widest_count   = widest_hits;
		res.pixel_count    = hit_total;
		res.horiz_mid      = hmid;
		res.vert_mid       = vmid;

		// frame done: statistics start over, registers stay
		col_ctr      = '0;
		row_idx      = '0;
		row_hits     = '0;
		row_hit_col  = '0;
		row_hit      = 1'b0;
		hit_total    = '0;
		hit_rows     = '0;
		last_hit_row = '0;
		widest_hits  = '0;
		widest_col   = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic crt_pkg::crt_pixel_t make_px(logic [7:0] r, logic [7:0] g,
		logic [7:0] b, logic fe);
		crt_pkg::crt_pixel_t px;
		px.red       = r;
		px.green     = g;
		px.blue      = b;
		px.frame_end = fe;
		return px;
	endfunction

	function automatic script_row_t px_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic fe);
		script_row_t row;
		row.is_cfg  = 1'b0;
		row.reg_idx = crt_pkg::REG_COLOR_SELECT;
		row.value   = '0;
		row.px      = make_px(r, g, b, fe);
		row.typed   = 1'b0;
		row.found   = 1'b0;
		row.offset  = '0;
		row.hits    = '0;
		return row;
	endfunction

	// frame-end pixel whose result is easy to read off by hand
	function automatic script_row_t px_exp(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic found, logic [15:0] offset, logic [31:0] hits);
		script_row_t row;
		row        = px_row(r, g, b, 1'b1);
		row.typed  = 1'b1;
		row.found  = found;
		row.offset = offset;
		row.hits   = hits;
		return row;
	endfunction

	function automatic script_row_t cfg_row(crt_pkg::crt_reg_t idx, logic [31:0] value);
		script_row_t row;
		row         = px_row(8'h00, 8'h00, 8'h00, 1'b0);
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.value   = value;
		return row;
	endfunction

	// channel sample on the requested side of a limit, random where that side is empty
	function automatic logic [7:0] pick_side(logic [7:0] limit, bit above);
		if (above)
			return (limit == 8'hFF) ? 8'($urandom) : 8'($urandom_range(255, int'(limit) + 1));
		return (limit == 8'h00) ? 8'($urandom) : 8'($urandom_range(int'(limit) - 1, 0));
	endfunction

	// Mostly pixels aimed at the current target so that frames build real rows,
	// plus full-scale extremes and plain noise.
	function automatic crt_pkg::crt_pixel_t make_pixel(bit last);
		int unsigned         mode;
		crt_pkg::crt_pixel_t px;
		mode = $urandom_range(99);
		px = make_px(8'($urandom), 8'($urandom), 8'($urandom), last);
		if (mode < 55) begin
			px.red   = pick_side(shadow.red_threshold,
				shadow.color_select == crt_pkg::COLOR_RED);
			px.green = pick_side(shadow.green_threshold,
				shadow.color_select == crt_pkg::COLOR_GREEN);
			px.blue  = pick_side(shadow.blue_threshold,
				shadow.color_select == crt_pkg::COLOR_BLUE);
		end else if (mode < 70) begin
			px.red   = {8{1'($urandom)}};
			px.green = {8{1'($urandom)}};
			px.blue  = {8{1'($urandom)}};
		end
		return px;
	endfunction

	function automatic logic [7:0] pick_level();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12)
			return 8'h00;
		if (r < 24)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// One pixel beat: optional idle cycles, then hold until accepted.
	// Typed expectations replace the predicted fields they name.
	task automatic push_pixel(crt_pkg::crt_pixel_t px, bit typed, logic found,
		logic [15:0] offset, logic [31:0] hits);
		crt_pkg::crt_result_t res;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {px.blue, px.green, px.red};
		s_tlast  = px.frame_end;
		do @(posedge clk); while (!s_tready);
		pixels_in++;
		if (track_pixel(px, res)) begin
			if (typed) begin
				res.found       = found;
				res.offset      = offset;
				res.pixel_count = hits;
			end
			frame_stats_q.push_back(res);
		end
	endtask

	// Stream goes quiet, every owed result drains, then a further DRAIN_CYCLES wait
	// for a pixel still in the pipe that ends no frame.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (frame_stats_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register
	task automatic reg_write(crt_pkg::crt_reg_t idx, logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		reg_writes++;
		case (idx)
			crt_pkg::REG_COLOR_SELECT:    shadow.color_select    = value[1:0];
			crt_pkg::REG_RED_THRESHOLD:   shadow.red_threshold   = value[7:0];
			crt_pkg::REG_GREEN_THRESHOLD: shadow.green_threshold = value[7:0];
			crt_pkg::REG_BLUE_THRESHOLD:  shadow.blue_threshold  = value[7:0];
			crt_pkg::REG_IMAGE_WIDTH:     shadow.image_width     = value[15:0];
			crt_pkg::REG_GRAY_MODE:       shadow.gray_mode       = value[0];
			default: ;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			crt_pkg::REG_COLOR_SELECT:    want = 32'(shadow.color_select);
			crt_pkg::REG_RED_THRESHOLD:   want = 32'(shadow.red_threshold);
			crt_pkg::REG_GREEN_THRESHOLD: want = 32'(shadow.green_threshold);
			crt_pkg::REG_BLUE_THRESHOLD:  want = 32'(shadow.blue_threshold);
			crt_pkg::REG_IMAGE_WIDTH:     want = 32'(shadow.image_width);
			default:                      want = 32'(shadow.gray_mode);
		endcase
		if (prdata !== want) begin
			$display("%0t: read-back %s expected %0h got %0h", $time, idx.name(), want,
				prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and field-by-field compare
	// ------------------------------------------------------------------

	always @(negedge clk)
		m_tready = gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.found          = m_tuser;
			got_res.offset         = m_tdata[15:0];
			got_res.last_match_row = m_tdata[31:16];
			got_res.widest_end_col = m_tdata[47:32];
			got_res.matching_rows  = m_tdata[63:48];
			got_res.widest_count   = m_tdata[79:64];
			got_res.pixel_count    = m_tdata[111:80];
			got_res.horiz_mid      = m_tdata[128:112];
			got_res.vert_mid       = m_tdata[145:129];
			if (frame_stats_q.size() == 0) begin
				$display("%0t: result beat with none expected, tdata %0h found %0b", $time,
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				want_res = frame_stats_q.pop_front();
				results_checked++;
				check_field("found",          32'(want_res.found),          32'(got_res.found));
				check_field("offset",         32'(want_res.offset),         32'(got_res.offset));
				check_field("last_match_row", 32'(want_res.last_match_row),
					32'(got_res.last_match_row));
				check_field("widest_end_col", 32'(want_res.widest_end_col),
					32'(got_res.widest_end_col));
				check_field("matching_rows",  32'(want_res.matching_rows),
					32'(got_res.matching_rows));
				check_field("widest_count",   32'(want_res.widest_count),
					32'(got_res.widest_count));
				check_field("pixel_count",    want_res.pixel_count,         got_res.pixel_count);
				check_field("horiz_mid",      32'(want_res.horiz_mid),      32'(got_res.horiz_mid));
				check_field("vert_mid",       32'(want_res.vert_mid),       32'(got_res.vert_mid));
				check_field("tdata padding",  32'h0,                        32'(m_tdata[151:146]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		script_row_t script[$];
		int unsigned random_items;
		int unsigned phase;
		int unsigned budget;
		int unsigned len;
		int unsigned r;
		bit          cut;
		logic [15:0] width;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed script. Starts on reset defaults: red target, limits 128, width 640.
		script.push_back(px_exp(8'hFF, 8'h00, 8'h00, 1'b1, 16'd640, 32'd1));
		// red exactly on its limit
		script.push_back(px_exp(8'd128, 8'd127, 8'd127, 1'b0, crt_pkg::OFFSET_NONE, 32'd0));
		script.push_back(px_exp(8'h00, 8'hFF, 8'hFF, 1'b0, crt_pkg::OFFSET_NONE, 32'd0));
		// three-pixel rows; frame end closes a partial second row
		script.push_back(cfg_row(crt_pkg::REG_IMAGE_WIDTH, 32'd3));
		script.push_back(px_row(8'd200, 8'd10, 8'd10, 1'b0));
		script.push_back(px_row(8'd10, 8'd10, 8'd10, 1'b0));
		script.push_back(px_row(8'd129, 8'd127, 8'd127, 1'b0));
		script.push_back(px_row(8'hFF, 8'h00, 8'h00, 1'b0));
		script.push_back(px_row(8'h00, 8'h00, 8'h00, 1'b1));
		// remaining targets, then the selector that matches nothing
		script.push_back(cfg_row(crt_pkg::REG_COLOR_SELECT, 32'(crt_pkg::COLOR_GREEN)));
		script.push_back(px_exp(8'h00, 8'hFF, 8'h00, 1'b1, 16'd3, 32'd1));
		script.push_back(cfg_row(crt_pkg::REG_COLOR_SELECT, 32'(crt_pkg::COLOR_BLUE)));
		script.push_back(px_exp(8'h00, 8'h00, 8'hFF, 1'b1, 16'd3, 32'd1));
		script.push_back(cfg_row(crt_pkg::REG_COLOR_SELECT, 32'(crt_pkg::COLOR_NONE)));
		script.push_back(px_row(8'hFF, 8'h00, 8'h00, 1'b0));
		script.push_back(px_exp(8'h00, 8'hFF, 8'h00, 1'b0, crt_pkg::OFFSET_NONE, 32'd0));
		// gray: red stands in for green and blue
		script.push_back(cfg_row(crt_pkg::REG_COLOR_SELECT, 32'(crt_pkg::COLOR_RED)));
		script.push_back(cfg_row(crt_pkg::REG_GRAY_MODE, 32'd1));
		script.push_back(px_exp(8'd200, 8'h00, 8'h00, 1'b0, crt_pkg::OFFSET_NONE, 32'd0));
		script.push_back(cfg_row(crt_pkg::REG_GREEN_THRESHOLD, 32'd255));
		script.push_back(cfg_row(crt_pkg::REG_BLUE_THRESHOLD, 32'd255));
		script.push_back(px_exp(8'd200, 8'hFF, 8'hFF, 1'b1, 16'd3, 32'd1));
		// width changes in the middle of a row of one frame
		script.push_back(cfg_row(crt_pkg::REG_GRAY_MODE, 32'd0));
		script.push_back(cfg_row(crt_pkg::REG_IMAGE_WIDTH, 32'd2));
		script.push_back(px_row(8'd200, 8'h00, 8'h00, 1'b0));
		script.push_back(px_row(8'd10, 8'd10, 8'd10, 1'b0));
		script.push_back(px_row(8'd200, 8'h00, 8'h00, 1'b0));
		script.push_back(cfg_row(crt_pkg::REG_IMAGE_WIDTH, 32'd5));
		script.push_back(px_row(8'd200, 8'h00, 8'h00, 1'b0));
		script.push_back(px_row(8'd200, 8'h00, 8'h00, 1'b0));
		script.push_back(px_row(8'h00, 8'h00, 8'h00, 1'b1));

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				reg_write(script[i].reg_idx, script[i].value);
			end else begin
				push_pixel(script[i].px, script[i].typed, script[i].found, script[i].offset,
					script[i].hits);
			end
		end

		// Long gap-free stretch: one frame at width 0, where only the frame end
		// closes the row, then a frame of one-pixel rows that all match.
		settle();
		gaps_on = 1'b0;
		reg_write(crt_pkg::REG_COLOR_SELECT, 32'(crt_pkg::COLOR_RED));
		reg_write(crt_pkg::REG_RED_THRESHOLD, 32'(crt_pkg::RST_THRESHOLD));
		reg_write(crt_pkg::REG_GREEN_THRESHOLD, 32'(crt_pkg::RST_THRESHOLD));
		reg_write(crt_pkg::REG_BLUE_THRESHOLD, 32'(crt_pkg::RST_THRESHOLD));
		reg_write(crt_pkg::REG_IMAGE_WIDTH, 32'd0);
		for (int n = 0; n < STRETCH_HALF; n++)
			push_pixel(make_pixel(n == STRETCH_HALF - 1), 1'b0, 1'b0, '0, '0);
		settle();
		reg_write(crt_pkg::REG_IMAGE_WIDTH, 32'd1);
		for (int n = 0; n < STRETCH_HALF; n++)
			push_pixel(make_px(8'hFF, 8'h00, 8'h00, n == STRETCH_HALF - 1), 1'b0, 1'b0,
				'0, '0);

		// Random phases: fresh settings at each idle point, then frames of random
		// length. A frame cut at the phase end carries on under the new settings.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			gaps_on = (phase != 1);
			r = $urandom_range(99);
			if (r < 65)
				width = 16'($urandom_range(8, 1));
			else if (r < 80)
				width = 16'($urandom_range(40, 9));
			else if (r < 88)
				width = 16'hFFFF;
			else if (r < 94)
				width = 16'($urandom_range(65535, 41));
			else
				width = 16'h0000;
			// upper pwdata bits carry junk the registers must drop
			reg_write(crt_pkg::REG_COLOR_SELECT, ($urandom() << 2) |
				32'(($urandom_range(9) == 0) ? crt_pkg::COLOR_NONE : $urandom_range(2)));
			reg_write(crt_pkg::REG_RED_THRESHOLD, ($urandom() << 8) | 32'(pick_level()));
			reg_write(crt_pkg::REG_GREEN_THRESHOLD, ($urandom() << 8) | 32'(pick_level()));
			reg_write(crt_pkg::REG_BLUE_THRESHOLD, ($urandom() << 8) | 32'(pick_level()));
			reg_write(crt_pkg::REG_IMAGE_WIDTH, ($urandom() << 16) | 32'(width));
			reg_write(crt_pkg::REG_GRAY_MODE,
				($urandom() << 1) | 32'($urandom_range(99) < 25));
			budget = $urandom_range(90, 30);
			while (budget > 0 && random_items < RANDOM_ITEMS) begin
				len = $urandom_range(24, 1);
				cut = len > budget;
				if (cut)
					len = budget;
				for (int k = 0; k < len; k++)
					push_pixel(make_pixel(!cut && k == len - 1), 1'b0, 1'b0, '0, '0);
				random_items += len;
				budget       -= len;
			end
			phase++;
		end

		settle();
		$display("tb_top: %0d pixels streamed, %0d frame results checked, %0d register writes",
			pixels_in, results_checked, reg_writes);
		$display("tb_top: all targets, limit extremes, gray mode, widths 0 and 1 exercised");
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(4 * LIMIT_CYCLES);
		$display("tb_top: timeout with %0d results still owed", frame_stats_q.size());
		$display("tb_top: errors");
		$finish;
	end

endmodule

>>> files.f
design/crt_pkg.sv
design/crt_cfg_regs.sv
design/crt_classify.sv
design/crt_stats.sv
design/crt_out_buf.sv
design/color_region_tracker_unit.sv
sim/tb_top.sv
